// ===== hw/rtl/array_table_search_engine_core_assert.svh =====
// Assertion macros for the array table search engine checker.
// Depends on clk and rst_n being visible where the macros are used.
`ifndef ARRAY_TABLE_SEARCH_ENGINE_CORE_ASSERT_SVH
`define ARRAY_TABLE_SEARCH_ENGINE_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define ATS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ats assertion failed");

// next-cycle implication, disabled in reset
`define ATS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ats assertion failed");

`endif

// ===== hw/rtl/ats_pkg.sv =====
// Shared types and constants of the array table search engine.
// No dependencies; used by the core and its checker.
package ats_pkg;

  localparam int DEPTH     = 256;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int OP_W      = 3;
  localparam int VAL_W     = 32;
  localparam int POS_W     = 9;
  localparam int ST_W      = 2;
  localparam int IDX_W     = 8;
  localparam int CNT_OUT_W = 9;
  localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
  localparam logic [OP_W-1:0] OP_LSRCH  = 3'd3;
  localparam logic [OP_W-1:0] OP_BSRCH  = 3'd4;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_MISS   = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
  localparam logic [ST_W-1:0] ST_BADPOS = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } ats_req_t;

  typedef struct packed {
    logic [ST_W-1:0]      status;
    logic [IDX_W-1:0]     index;
    logic [CNT_OUT_W-1:0] count;
  } ats_rsp_t;

endpackage

// ===== hw/rtl/array_table_search_engine_core.sv =====
// Array table search engine: one word memory with a registered read port.
// Depends on ats_pkg.
//
// The block holds up to DEPTH signed words in a single-port-read memory and
// serves one request at a time. Linear search reads one stored word per
// cycle until a hit or the end of the table; binary search reads and
// compares one word per halving step; insert moves one word per cycle from
// the end down to the position and then writes a zero there, or writes the
// zero directly when the position equals the length. The searches and the
// insert are paced by the one read port of the word memory. The next
// request is accepted while the previous result waits on the output register.
module array_table_search_engine_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  ats_pkg::ats_req_t in_req,
  output logic             out_valid,
  input  logic             out_stall,
  output ats_pkg::ats_rsp_t out_rsp
);
  import ats_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LIN  = 3'd1;
  localparam logic [2:0] S_BSET = 3'd2;
  localparam logic [2:0] S_BCMP = 3'd3;
  localparam logic [2:0] S_INS  = 3'd4;
  localparam logic [2:0] S_INSZ = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rdata_r;

  logic [2:0]              state_r, state_nxt;
  logic [CNT_W-1:0]        len_r, len_nxt;
  logic signed [VAL_W-1:0] key_r, key_nxt;
  logic [AW-1:0]           ptr_r, ptr_nxt;
  logic [AW-1:0]           pos_r, pos_nxt;
  logic [CNT_W-1:0]        lo_r, lo_nxt;
  logic [CNT_W-1:0]        hi_r, hi_nxt;
  logic [AW-1:0]           mid_r, mid_nxt;
  logic [ST_W-1:0]         st_r, st_nxt;
  logic [AW-1:0]           idx_r, idx_nxt;
  logic                    out_valid_r;
  ats_rsp_t                out_rsp_r;

  logic [AW-1:0]    rd_addr;
  logic             we;
  logic [AW-1:0]    wa;
  logic [VAL_W-1:0] wd;
  logic             full;
  logic             pos_bad;
  logic             pos_end;
  logic [CNT_W:0]   lohi_sum;
  logic             out_free;

  assign full     = (len_r == CNT_W'(DEPTH));
  assign pos_bad  = (CMP_W'(in_req.position) > CMP_W'(len_r));
  assign pos_end  = (CMP_W'(in_req.position) == CMP_W'(len_r));
  assign lohi_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign out_free = !out_valid_r || !out_stall;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    key_nxt   = key_r;
    ptr_nxt   = ptr_r;
    pos_nxt   = pos_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    st_nxt    = st_r;
    idx_nxt   = idx_r;
    rd_addr   = '0;
    we        = 1'b0;
    wa        = '0;
    wd        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          key_nxt   = in_req.value;
          st_nxt    = ST_OK;
          idx_nxt   = '0;
          state_nxt = S_FIN;
          unique case (in_req.operation)
            OP_CLEAR: begin
              len_nxt = '0;
            end
            OP_APPEND: begin
              if (full) begin
                st_nxt = ST_FULL;
              end else begin
                we      = 1'b1;
                wa      = AW'(len_r);
                wd      = in_req.value;
                len_nxt = len_r + CNT_W'(1);
              end
            end
            OP_INSERT: begin
              if (pos_bad) begin
                st_nxt = ST_BADPOS;
              end else if (full) begin
                st_nxt = ST_FULL;
              end else if (pos_end) begin
                we      = 1'b1;
                wa      = AW'(in_req.position);
                wd      = '0;
                len_nxt = len_r + CNT_W'(1);
              end else begin
                pos_nxt   = AW'(in_req.position);
                rd_addr   = AW'(len_r - CNT_W'(1));
                ptr_nxt   = AW'(len_r - CNT_W'(1));
                state_nxt = S_INS;
              end
            end
            OP_LSRCH: begin
              st_nxt = ST_MISS;
              if (len_r != '0) begin
                rd_addr   = '0;
                ptr_nxt   = '0;
                state_nxt = S_LIN;
              end
            end
            OP_BSRCH: begin
              st_nxt    = ST_MISS;
              lo_nxt    = '0;
              hi_nxt    = len_r;
              state_nxt = S_BSET;
            end
            default: begin
            end
          endcase
        end
      end
      S_LIN: begin
        if (rdata_r == key_r) begin
          st_nxt    = ST_OK;
          idx_nxt   = ptr_r;
          state_nxt = S_FIN;
        end else if (CNT_W'(ptr_r) + CNT_W'(1) == len_r) begin
          state_nxt = S_FIN;
        end else begin
          rd_addr = ptr_r + AW'(1);
          ptr_nxt = ptr_r + AW'(1);
        end
      end
      S_BSET: begin
        if (lo_r < hi_r) begin
          rd_addr   = AW'(lohi_sum >> 1);
          mid_nxt   = AW'(lohi_sum >> 1);
          state_nxt = S_BCMP;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_BCMP: begin
        if (rdata_r == key_r) begin
          st_nxt    = ST_OK;
          idx_nxt   = mid_r;
          state_nxt = S_FIN;
        end else begin
          if ($signed(rdata_r) < key_r) begin
            lo_nxt = CNT_W'(mid_r) + CNT_W'(1);
          end else begin
            hi_nxt = CNT_W'(mid_r);
          end
          state_nxt = S_BSET;
        end
      end
      S_INS: begin
        we = 1'b1;
        wa = ptr_r + AW'(1);
        wd = rdata_r;
        if (ptr_r == pos_r) begin
          state_nxt = S_INSZ;
        end else begin
          rd_addr = ptr_r - AW'(1);
          ptr_nxt = ptr_r - AW'(1);
        end
      end
      S_INSZ: begin
        we        = 1'b1;
        wa        = pos_r;
        wd        = '0;
        len_nxt   = len_r + CNT_W'(1);
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r   <= '0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    ptr_r <= ptr_nxt;
    pos_r <= pos_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    mid_r <= mid_nxt;
    st_r  <= st_nxt;
    idx_r <= idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIN && out_free) begin
      out_rsp_r.status <= st_r;
      out_rsp_r.index  <= IDX_W'(idx_r);
      out_rsp_r.count  <= CNT_OUT_W'(len_r);
    end
  end

endmodule

// ===== hw/rtl/ats_chk.sv =====
// Port-level checker for the array table search engine, with its bind.
// Depends on ats_pkg and array_table_search_engine_core_assert.svh.
`include "array_table_search_engine_core_assert.svh"

module ats_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input ats_pkg::ats_req_t in_req,
  input logic              out_valid,
  input logic              out_stall,
  input ats_pkg::ats_rsp_t out_rsp
);
  import ats_pkg::*;

  `ATS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_rsp))
  `ATS_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall)
  `ATS_ASSERT_NOW(a_count_range, out_valid, out_rsp.count <= CNT_OUT_W'(DEPTH))
  `ATS_ASSERT_NOW(a_full_count, out_valid && out_rsp.status == ST_FULL, out_rsp.count == CNT_OUT_W'(DEPTH))

endmodule

bind array_table_search_engine_core ats_chk u_ats_chk (.*);
